>>> src/pbq_pkg.sv
package pbq_pkg;

    // Default pool size and fixed buffer geometry.
    localparam int DEF_BUFFER_COUNT = 4;
    localparam int MAX_SAMPLES      = 1024;
    localparam int BUFFER_BYTES     = 4096;

    localparam int SAMPLE_W = 11;

    // Request codes.
    localparam logic [1:0] REQ_SUBMIT      = 2'd0;
    localparam logic [1:0] REQ_COMPLETE    = 2'd1;
    localparam logic [1:0] REQ_SLOT_NOTICE = 2'd2;

    // Status codes.
    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_WOULD_BLOCK = 2'd1;
    localparam logic [1:0] ST_MUST_WAIT   = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SAMPLE_16BIT = 2'd0;
    localparam logic [1:0] CFG_STEREO_MODE  = 2'd1;
    localparam logic [1:0] CFG_BUFFER_BASE  = 2'd2;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [19:0] byte_length;
        logic        blocking;
        logic        slot_ready;
    } pcm_req_t;

    typedef struct packed {
        logic [1:0]          status;
        logic [12:0]         bytes_accepted;
        logic [1:0]          buffer_index;
        logic                handoff_valid;
        logic [22:0]         handoff_address;
        logic [SAMPLE_W-1:0] handoff_samples;
        logic                free_available;
    } pcm_rsp_t;

endpackage

>>> src/pbq_ram.sv
module pbq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        // Read data holds between reads.
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> src/pcm_buffer_queue_handoff.sv
// PCM playback buffer queue. A pool of BUFFER_COUNT buffers circulates between a free
// FIFO and a busy FIFO, both held in small synchronous RAMs; a submit moves the oldest
// free buffer to busy, a completion returns the oldest busy buffer to free, and after
// every request the oldest busy buffer not yet handed off goes to the playback slot
// when slot_ready is set. A request walks the steps idle, apply, lookup and result:
// idle reads both queue heads as it accepts, apply updates the queues, lookup makes
// the handoff read, a second read of the busy RAM through its single read port, and
// result registers the beat. The next request is taken in the cycle after the result
// is registered; if the previous result still waits in the output register, the new
// request is taken all the same and holds in its last step until that beat leaves.
// The free queue starts out holding every buffer in order, with no clearing pass
// after reset.
module pcm_buffer_queue_handoff
    import pbq_pkg::*;
#(
    parameter int BUFFER_COUNT = DEF_BUFFER_COUNT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  pcm_req_t    in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output pcm_rsp_t    out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [22:0] cfg_data
);

    localparam int IW = $clog2(BUFFER_COUNT);
    localparam int CW = $clog2(BUFFER_COUNT + 1);
    localparam int BW = IW + SAMPLE_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_APPLY,
        S_LOOKUP,
        S_RESULT
    } state_t;

    function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] base,
                                               input logic [CW-1:0] off);
        logic [CW:0] sum;
        sum = (CW+1)'(base) + (CW+1)'(off);
        if (sum >= (CW+1)'(BUFFER_COUNT))
        begin
            sum = sum - (CW+1)'(BUFFER_COUNT);
        end
        return sum[IW-1:0];
    endfunction

    state_t            state_reg, state_next;
    pcm_req_t          req_reg, req_next;
    logic              sample16_reg;
    logic              stereo_reg;
    logic [22:0]       base_reg;
    logic [IW-1:0]     free_head_reg, free_head_next;
    logic [CW-1:0]     free_count_reg, free_count_next;
    logic [IW-1:0]     busy_head_reg, busy_head_next;
    logic [CW-1:0]     busy_count_reg, busy_count_next;
    logic [CW-1:0]     queued_reg, queued_next;
    logic [BUFFER_COUNT-1:0] free_vld_reg, free_vld_next;
    logic              head_vld_reg, head_vld_next;
    logic [1:0]        status_reg, status_next;
    logic [12:0]       accepted_reg, accepted_next;
    logic [IW-1:0]     taken_reg, taken_next;
    logic              hand_reg, hand_next;
    logic              out_valid_reg, out_valid_next;
    pcm_rsp_t          out_data_reg, out_data_next;

    logic              free_we, free_re;
    logic [IW-1:0]     free_waddr, free_wdata, free_rdata;
    logic              busy_we, busy_re;
    logic [IW-1:0]     busy_waddr, busy_raddr;
    logic [BW-1:0]     busy_wdata, busy_rdata;

    logic [IW-1:0]       free_entry;
    logic [19:0]         shifted;
    logic [SAMPLE_W-1:0] samples;
    logic [12:0]         accepted;
    logic [IW-1:0]       hand_idx;
    logic [22:0]         hand_offset;

    pbq_ram #(
        .WIDTH (IW),
        .DEPTH (BUFFER_COUNT)
    ) u_free_ram (
        .clk   (clk),
        .we    (free_we),
        .waddr (free_waddr),
        .wdata (free_wdata),
        .re    (free_re),
        .raddr (free_head_reg),
        .rdata (free_rdata)
    );

    // Each busy entry carries its buffer index and that buffer's sample count.
    pbq_ram #(
        .WIDTH (BW),
        .DEPTH (BUFFER_COUNT)
    ) u_busy_ram (
        .clk   (clk),
        .we    (busy_we),
        .waddr (busy_waddr),
        .wdata (busy_wdata),
        .re    (busy_re),
        .raddr (busy_raddr),
        .rdata (busy_rdata)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // A free slot that was never written still holds its reset value, its own position.
    assign free_entry = head_vld_reg ? free_rdata : free_head_reg;

    always_comb
    begin
        shifted = req_reg.byte_length;
        if (sample16_reg)
        begin
            shifted = shifted >> 1;
        end
        if (stereo_reg)
        begin
            shifted = shifted >> 1;
        end
        if (shifted > 20'(MAX_SAMPLES))
        begin
            samples = SAMPLE_W'(MAX_SAMPLES);
        end
        else
        begin
            samples = shifted[SAMPLE_W-1:0];
        end
        if (!sample16_reg && !stereo_reg)
        begin
            samples[0] = 1'b0;
        end
        accepted = 13'(samples);
        if (sample16_reg)
        begin
            accepted = accepted << 1;
        end
        if (stereo_reg)
        begin
            accepted = accepted << 1;
        end
    end

    assign hand_idx    = busy_rdata[BW-1:SAMPLE_W];
    assign hand_offset = base_reg + 23'(BUFFER_BYTES) * 23'(hand_idx);

    always_comb
    begin
        state_next      = state_reg;
        req_next        = req_reg;
        free_head_next  = free_head_reg;
        free_count_next = free_count_reg;
        busy_head_next  = busy_head_reg;
        busy_count_next = busy_count_reg;
        queued_next     = queued_reg;
        free_vld_next   = free_vld_reg;
        head_vld_next   = head_vld_reg;
        status_next     = status_reg;
        accepted_next   = accepted_reg;
        taken_next      = taken_reg;
        hand_next       = hand_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_data_next   = out_data_reg;

        free_we    = 1'b0;
        free_re    = 1'b0;
        free_waddr = wrap_add(free_head_reg, free_count_reg);
        free_wdata = busy_rdata[BW-1:SAMPLE_W];
        busy_we    = 1'b0;
        busy_re    = 1'b0;
        busy_waddr = wrap_add(busy_head_reg, busy_count_reg);
        busy_wdata = {free_entry, samples};
        busy_raddr = busy_head_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    // Read both queue heads; a completion needs the busy head.
                    free_re       = 1'b1;
                    busy_re       = 1'b1;
                    req_next      = in_data;
                    head_vld_next = free_vld_reg[free_head_reg];
                    status_next   = ST_OK;
                    accepted_next = '0;
                    taken_next    = '0;
                    state_next    = S_APPLY;
                end
            end
            S_APPLY:
            begin
                if (req_reg.req_type == REQ_SUBMIT)
                begin
                    if (free_count_reg == '0)
                    begin
                        status_next = req_reg.blocking ? ST_MUST_WAIT : ST_WOULD_BLOCK;
                    end
                    else
                    begin
                        busy_we         = 1'b1;
                        free_head_next  = wrap_add(free_head_reg, CW'(1));
                        free_count_next = free_count_reg - CW'(1);
                        busy_count_next = busy_count_reg + CW'(1);
                        accepted_next   = accepted;
                        taken_next      = free_entry;
                    end
                end
                else if (req_reg.req_type == REQ_COMPLETE && busy_count_reg != '0)
                begin
                    free_we                   = 1'b1;
                    free_vld_next[free_waddr] = 1'b1;
                    free_count_next           = free_count_reg + CW'(1);
                    busy_head_next            = wrap_add(busy_head_reg, CW'(1));
                    busy_count_next           = busy_count_reg - CW'(1);
                    if (queued_reg != '0)
                    begin
                        queued_next = queued_reg - CW'(1);
                    end
                end
                state_next = S_LOOKUP;
            end
            S_LOOKUP:
            begin
                // Handed-off buffers form the front of the busy queue.
                busy_re    = 1'b1;
                busy_raddr = wrap_add(busy_head_reg, queued_reg);
                hand_next  = req_reg.slot_ready && (queued_reg < busy_count_reg);
                if (hand_next)
                begin
                    queued_next = queued_reg + CW'(1);
                end
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next                 = 1'b1;
                    out_data_next.status           = status_reg;
                    out_data_next.bytes_accepted   = accepted_reg;
                    out_data_next.buffer_index     = 2'(taken_reg);
                    out_data_next.handoff_valid    = hand_reg;
                    out_data_next.handoff_address  = hand_reg ? {1'b0, hand_offset[22:1]} : '0;
                    out_data_next.handoff_samples  =
                        hand_reg ? busy_rdata[SAMPLE_W-1:0] : '0;
                    out_data_next.free_available   = (free_count_reg != '0);
                    state_next                     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            req_reg        <= '0;
            sample16_reg   <= 1'b1;
            stereo_reg     <= 1'b1;
            base_reg       <= '0;
            free_head_reg  <= '0;
            free_count_reg <= CW'(BUFFER_COUNT);
            busy_head_reg  <= '0;
            busy_count_reg <= '0;
            queued_reg     <= '0;
            free_vld_reg   <= '0;
            head_vld_reg   <= 1'b0;
            status_reg     <= ST_OK;
            accepted_reg   <= '0;
            taken_reg      <= '0;
            hand_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_data_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            req_reg        <= req_next;
            free_head_reg  <= free_head_next;
            free_count_reg <= free_count_next;
            busy_head_reg  <= busy_head_next;
            busy_count_reg <= busy_count_next;
            queued_reg     <= queued_next;
            free_vld_reg   <= free_vld_next;
            head_vld_reg   <= head_vld_next;
            status_reg     <= status_next;
            accepted_reg   <= accepted_next;
            taken_reg      <= taken_next;
            hand_reg       <= hand_next;
            out_valid_reg  <= out_valid_next;
            out_data_reg   <= out_data_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_SAMPLE_16BIT: sample16_reg <= cfg_data[0];
                    CFG_STEREO_MODE:  stereo_reg   <= cfg_data[0];
                    CFG_BUFFER_BASE:  base_reg     <= cfg_data;
                    default:          ;
                endcase
            end
        end
    end

`ifndef SYNTH
    // Every buffer is in exactly one of the two queues.
    assert property (@(posedge clk) disable iff (!rst_n)
        (CW+1)'(free_count_reg) + (CW+1)'(busy_count_reg) == (CW+1)'(BUFFER_COUNT))
    else $error("free and busy counts do not cover the pool");

    assert property (@(posedge clk) disable iff (!rst_n)
        queued_reg <= busy_count_reg)
    else $error("more buffers handed off than are busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_RESULT))
    else $error("result beat raised outside the result step");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.status != ST_OK |-> out_data_reg.bytes_accepted == '0)
    else $error("bytes reported on a refused submit");
`endif

endmodule
